>>> src/pfdc_pkg.sv
// Shared constants and the result type of the prime factorizer.
`timescale 1ns / 1ps

package pfdc_pkg;

  localparam int WIDTH_DEF = 32;
  localparam int NUM_W     = 32;
  localparam int PRIME_W   = 32;
  localparam int EXP_W     = 5;
  localparam int DC_W      = 11;
  localparam int PC_W      = 5;
  localparam int FIRST_DIV = 2;

  typedef struct packed {
    logic [PRIME_W-1:0] prime;
    logic [EXP_W-1:0]   exponent;
    logic [DC_W-1:0]    divisor_count;
    logic [PC_W-1:0]    prime_count;
    logic               last;
  } result_t;

endpackage

>>> src/pfdc_div.sv
// Bit-serial restoring divider that yields quotient and remainder.
`timescale 1ns / 1ps

module pfdc_div #(
  parameter int WIDTH = pfdc_pkg::WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [WIDTH-1:0] quo,
  output logic [WIDTH-1:0] rem
);
  import pfdc_pkg::*;

  localparam int CNT_W = $clog2(WIDTH + 1);

  logic [CNT_W-1:0] cnt;
  logic [WIDTH-1:0] q;
  logic [WIDTH-1:0] part;
  logic [WIDTH-1:0] dvsr;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;
  logic             ge;

  // One quotient bit per cycle; the borrow of the trial subtract decides it.
  assign shifted = {part, q[WIDTH-1]};
  assign diff    = shifted - {1'b0, dvsr};
  assign ge      = ~diff[WIDTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q    <= dividend;
        part <= '0;
        dvsr <= divisor;
        cnt  <= CNT_W'(WIDTH);
        busy <= 1'b1;
      end else if (busy) begin
        q    <= {q[WIDTH-2:0], ge};
        part <= ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = q;
  assign rem = part;

endmodule

>>> src/pfdc_oreg.sv
// Output register that holds one result until the receiver takes it.
`timescale 1ns / 1ps

module pfdc_oreg (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  pfdc_pkg::result_t din,
  output logic              ready,
  output logic              out_valid,
  output pfdc_pkg::result_t dout,
  input  logic              out_stall
);
  import pfdc_pkg::*;

  assign ready = ~out_valid | ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      dout <= din;
    end
  end

endmodule

>>> src/prime_factorizer_divisor_count.sv
// Top level of the trial-division prime factorizer with divisor count.
//
// A request on the input channel (number, in_valid, in_stall) carries one
// unsigned number. The block answers with one result per distinct prime in
// ascending order on the output channel (prime, exponent, divisor_count,
// prime_count, last, out_valid, out_stall). The final result has last set and
// carries the divisor count and the prime count; earlier results carry zero
// there. Zero and one give a single last result with prime 0.
// One request is worked on at a time. Each trial division runs through a
// bit-serial divider, one quotient bit per cycle. Candidate divisors are
// tried upward from 2 while their square does not exceed the cofactor left,
// and each found prime divides the cofactor again until a remainder shows.
// A new request is taken as soon as the last result sits in the output
// register, even while the receiver stalls. A stalled receiver holds the
// search at the next result to be emitted. Reset empties the output register
// and returns the sequencer to idle.
`timescale 1ns / 1ps

module prime_factorizer_divisor_count #(
  parameter int WIDTH = pfdc_pkg::WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [pfdc_pkg::NUM_W-1:0]   number,
  input  logic                         in_valid,
  output logic                         in_stall,
  output logic [pfdc_pkg::PRIME_W-1:0] prime,
  output logic [pfdc_pkg::EXP_W-1:0]   exponent,
  output logic [pfdc_pkg::DC_W-1:0]    divisor_count,
  output logic [pfdc_pkg::PC_W-1:0]    prime_count,
  output logic                         last,
  output logic                         out_valid,
  input  logic                         out_stall
);
  import pfdc_pkg::*;

  localparam int SQ_W = WIDTH + 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_DIV   = 5'b00100,
    S_REC   = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t           state;
  logic [WIDTH-1:0] r;
  logic [WIDTH-1:0] d;
  logic [SQ_W-1:0]  sq;
  logic [EXP_W-1:0] e;
  logic [DC_W-1:0]  dc;
  logic [PC_W-1:0]  pc;
  logic             pend_valid;
  logic [WIDTH-1:0] pend_prime;
  logic [EXP_W-1:0] pend_exp;
  logic             tiny;

  logic             accept;
  logic [WIDTH-1:0] n_in;
  logic             in_range;
  logic [EXP_W:0]   e_inc;
  logic [DC_W+EXP_W:0] dc_prod;

  logic             div_start;
  logic [WIDTH-1:0] div_dividend;
  logic             div_busy;
  logic             div_done;
  logic [WIDTH-1:0] div_quo;
  logic [WIDTH-1:0] div_rem;

  logic             push;
  logic             push_ok;
  result_t          push_data;
  result_t          out_data;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid & ~in_stall;
  assign n_in     = WIDTH'(number);
  assign in_range = (sq <= {1'b0, r});
  assign e_inc    = {1'b0, e} + 1'b1;
  assign dc_prod  = dc * e_inc;

  pfdc_div #(
    .WIDTH(WIDTH)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (d),
    .busy    (div_busy),
    .done    (div_done),
    .quo     (div_quo),
    .rem     (div_rem)
  );

  pfdc_oreg u_oreg (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .din      (push_data),
    .ready    (push_ok),
    .out_valid(out_valid),
    .dout     (out_data),
    .out_stall(out_stall)
  );

  always_comb begin
    div_start    = 1'b0;
    div_dividend = r;
    push         = 1'b0;
    push_data    = '0;
    unique case (state)
      S_CHECK: begin
        div_start = in_range;
      end
      S_DIV: begin
        // An exact division restarts at once on the quotient.
        if (div_done && div_rem == '0) begin
          div_start    = 1'b1;
          div_dividend = div_quo;
        end
      end
      S_REC: begin
        if (pend_valid && push_ok) begin
          push               = 1'b1;
          push_data.prime    = PRIME_W'(pend_prime);
          push_data.exponent = pend_exp;
        end
      end
      S_FIN: begin
        if (push_ok) begin
          push = 1'b1;
          if (tiny) begin
            push_data.divisor_count = DC_W'(1);
            push_data.last          = 1'b1;
          end else if (r != WIDTH'(1)) begin
            if (pend_valid) begin
              push_data.prime    = PRIME_W'(pend_prime);
              push_data.exponent = pend_exp;
            end else begin
              // The cofactor left over is itself a prime.
              push_data.prime         = PRIME_W'(r);
              push_data.exponent      = EXP_W'(1);
              push_data.divisor_count = {dc[DC_W-2:0], 1'b0};
              push_data.prime_count   = pc + 1'b1;
              push_data.last          = 1'b1;
            end
          end else begin
            push_data.prime         = PRIME_W'(pend_prime);
            push_data.exponent      = pend_exp;
            push_data.divisor_count = dc;
            push_data.prime_count   = pc;
            push_data.last          = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend_valid <= 1'b0;
      tiny       <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            r          <= n_in;
            d          <= WIDTH'(FIRST_DIV);
            sq         <= SQ_W'(FIRST_DIV * FIRST_DIV);
            e          <= '0;
            dc         <= DC_W'(1);
            pc         <= '0;
            pend_valid <= 1'b0;
            tiny       <= (n_in[WIDTH-1:1] == '0);
            state      <= (n_in[WIDTH-1:1] == '0) ? S_FIN : S_CHECK;
          end
        end
        S_CHECK: begin
          state <= in_range ? S_DIV : S_FIN;
        end
        S_DIV: begin
          if (div_done) begin
            if (div_rem == '0) begin
              r <= div_quo;
              e <= e + 1'b1;
            end else if (e != '0) begin
              state <= S_REC;
            end else begin
              d     <= d + 1'b1;
              sq    <= sq + {d, 1'b1};
              state <= S_CHECK;
            end
          end
        end
        S_REC: begin
          // The prime found before this one goes out first, as a plain result.
          if (!pend_valid || push_ok) begin
            pend_prime <= d;
            pend_exp   <= e;
            pend_valid <= 1'b1;
            dc         <= dc_prod[DC_W-1:0];
            pc         <= pc + PC_W'(e);
            e          <= '0;
            d          <= d + 1'b1;
            sq         <= sq + {d, 1'b1};
            state      <= S_CHECK;
          end
        end
        S_FIN: begin
          if (push_ok) begin
            pend_valid <= 1'b0;
            if (tiny || r == WIDTH'(1) || !pend_valid) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign prime         = out_data.prime;
  assign exponent      = out_data.exponent;
  assign divisor_count = out_data.divisor_count;
  assign prime_count   = out_data.prime_count;
  assign last          = out_data.last;

  a_div_only_in_div: assert property (@(posedge clk) disable iff (rst)
    (state != S_DIV) |-> !div_busy)
    else $error("divider runs outside the division state");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push |-> push_ok)
    else $error("result pushed into a full, stalled output register");

  a_cofactor_one_has_pending: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && !tiny && r == WIDTH'(1)) |-> pend_valid)
    else $error("finished with a unit cofactor but no prime recorded");

  a_early_results_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> (divisor_count == '0 && prime_count == '0))
    else $error("non-final result carries totals");

endmodule

>>> verif/prime_factorizer_divisor_count_tb.sv
// Self-checking testbench for the trial-division prime factorizer with divisor count.
`timescale 1ns / 1ps

module prime_factorizer_divisor_count_tb;
  import pfdc_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES   = 100;
  localparam int unsigned RANDOM_ITEMS   = 100;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic [NUM_W-1:0]   number = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [PRIME_W-1:0] prime;
  logic [EXP_W-1:0]   exponent;
  logic [DC_W-1:0]    divisor_count;
  logic [PC_W-1:0]    prime_count;
  logic               last;
  logic               out_valid;
  logic               out_stall = 1'b0;

  logic [NUM_W-1:0] numbers_to_send[$];
  result_t          pending_factors[$];
  int unsigned      total_count = 1;
  int unsigned      sent_count = 0;
  int unsigned      mismatches = 0;
  int unsigned      quiet_cycles = 0;

  prime_factorizer_divisor_count u_dut (
    .clk           (clk),
    .rst           (rst),
    .number        (number),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .prime         (prime),
    .exponent      (exponent),
    .divisor_count (divisor_count),
    .prime_count   (prime_count),
    .last          (last),
    .out_valid     (out_valid),
    .out_stall     (out_stall)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Factor one number by trial division and queue the results it must produce.
  task automatic factorize(input logic [NUM_W-1:0] value);
    logic [63:0] rem;
    logic [63:0] cand;
    int unsigned ndiv;
    int unsigned nprime;
    int unsigned e;
    result_t     r;
    result_t     found[$];
    ndiv   = 1;
    nprime = 0;
    rem    = 64'(value);
    cand   = 64'(FIRST_DIV);
    if (value < 2) begin
      rem = '0;
      r = '0;
      found.push_back(r);
    end
    while (rem > 1 && cand * cand <= rem) begin
      if (rem % cand == 0) begin
        e = 0;
        while (rem % cand == 0) begin
          rem = rem / cand;
          e++;
        end
        ndiv   = ndiv * (e + 1);
        nprime = nprime + e;
        r = '0;
        r.prime    = cand[PRIME_W-1:0];
        r.exponent = e[EXP_W-1:0];
        found.push_back(r);
      end
      cand++;
    end
    if (rem > 1) begin
      ndiv   = ndiv * 2;
      nprime = nprime + 1;
      r = '0;
      r.prime    = rem[PRIME_W-1:0];
      r.exponent = EXP_W'(1);
      found.push_back(r);
    end
    found[found.size()-1].divisor_count = ndiv[DC_W-1:0];
    found[found.size()-1].prime_count   = nprime[PC_W-1:0];
    found[found.size()-1].last          = 1'b1;
    foreach (found[k]) pending_factors.push_back(found[k]);
  endtask

  // Product of random factors up to max_factor, kept at or below limit.
  function automatic logic [NUM_W-1:0] smooth_number(int unsigned max_factor,
                                                     logic [63:0] limit);
    logic [63:0] prod;
    int unsigned f;
    prod = 1;
    for (int i = 0; i < 40; i++) begin
      f = $urandom_range(max_factor, 2);
      if (prod * f <= limit) prod = prod * f;
    end
    return prod[NUM_W-1:0];
  endfunction

  function automatic int unsigned sender_idle_pct();
    case (sent_count * 4 / total_count)
      1:       return 61;
      3:       return 34;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned receiver_stall_pct();
    case (sent_count * 4 / total_count)
      2:       return 61;
      3:       return 34;
      default: return 0;
    endcase
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] seen);
    if (seen !== want) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, seen);
    end
  endtask

  // Request driver: the payload holds while stalled, and prediction happens on acceptance.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        factorize(number);
        sent_count <= sent_count + 1;
      end
      if (!in_valid || !in_stall) begin
        if (numbers_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
          number   <= numbers_to_send.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct());
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_factors.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: expected none, actual prime %0d exponent %0d last %0b",
                 $time, prime, exponent, last);
      end else begin
        want = pending_factors.pop_front();
        check_field("prime", 32'(want.prime), 32'(prime));
        check_field("exponent", 32'(want.exponent), 32'(exponent));
        check_field("divisor_count", 32'(want.divisor_count), 32'(divisor_count));
        check_field("prime_count", 32'(want.prime_count), 32'(prime_count));
        check_field("last", 32'(want.last), 32'(last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned      pick;
    int unsigned      cof;
    logic [NUM_W-1:0] value;
    numbers_to_send.push_back(32'd0);
    numbers_to_send.push_back(32'd1);
    numbers_to_send.push_back(32'd2);
    numbers_to_send.push_back(32'd3);
    numbers_to_send.push_back(32'd4);
    numbers_to_send.push_back(32'd12);
    numbers_to_send.push_back(32'd97);
    numbers_to_send.push_back(32'h8000_0000);   // exponent and prime count at their maximum
    numbers_to_send.push_back(32'hFFFF_FFFF);
    numbers_to_send.push_back(32'hAAAA_AAAA);
    numbers_to_send.push_back(32'h5555_5555);
    numbers_to_send.push_back(32'hC000_0000);
    numbers_to_send.push_back(32'd3486784401);  // a pure power of three
    numbers_to_send.push_back(32'd3569485920);  // nine distinct primes
    numbers_to_send.push_back(32'd65521);
    numbers_to_send.push_back(32'd1000003);     // leftover cofactor is a large prime
    numbers_to_send.push_back(32'd1018081);     // square of a prime
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        value = $urandom_range(1000, 0);
      end else if (pick < 60) begin
        value = smooth_number(50, 64'hFFFF_FFFF);
      end else if (pick < 75) begin
        value = smooth_number(300, {32'h0, $urandom()});
      end else if (pick < 90) begin
        value = smooth_number(50, {32'h0, $urandom()});
      end else begin
        cof   = $urandom_range(100000, 1000);
        value = smooth_number(50, 64'hFFFF_FFFF / cof) * cof;
      end
      numbers_to_send.push_back(value);
    end
    total_count = numbers_to_send.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (sent_count != total_count) @(posedge clk);
    while (pending_factors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
